### hw/rtl/ptq_pkg.sv
// ============================================================================
// ptq_pkg - shared definitions for the periodic timer queue
// Field widths, action codes and the command/status bundles that pass
// between the controller and the datapath.
// ============================================================================
package ptq_pkg;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int ID_W     = 32;
   localparam int INTV_W   = 32;
   localparam int NOW_W    = 48;
   localparam int DL_W     = 64;
   localparam int WAIT_W   = 32;

   // Wait reported when no timer is armed: one hour in milliseconds
   localparam logic [WAIT_W-1:0] WAIT_WHEN_EMPTY = WAIT_W'(60 * 60 * 1000);

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_SET  = 2'd0,
      ACT_KILL = 2'd1,
      ACT_POLL = 2'd2,
      ACT_WAIT = 2'd3
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;   // input beat may be taken
      logic load_item;   // capture the input beat and clear scan trackers
      logic issue;       // read the slot at the scan address
      logic commit;      // update the table and load the result register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;   // an input beat is offered
      logic out_busy;    // result register holds a beat not yet taken
   } dp_status_type;

endpackage

### hw/rtl/ptq_channels.sv
// ============================================================================
// ptq_channels - request and response channels of the timer queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface ptq_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptq_pkg::ACTION_W-1:0]  action;
   logic [ptq_pkg::ID_W-1:0]      timer_id;
   logic [ptq_pkg::INTV_W-1:0]    interval_ms;
   logic [ptq_pkg::NOW_W-1:0]     now_ms;

   modport source (output valid, output action, output timer_id, output interval_ms,
                   output now_ms, input ready);
   modport sink   (input valid, input action, input timer_id, input interval_ms,
                   input now_ms, output ready);
endinterface

interface ptq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        fired;
   logic [ptq_pkg::ID_W-1:0]    fired_id;
   logic [ptq_pkg::WAIT_W-1:0]  wait_ms;
   logic                        is_empty;
   logic                        status;

   modport source (output valid, output fired, output fired_id, output wait_ms,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input fired, input fired_id, input wait_ms,
                   input is_empty, input status, output ready);
endinterface

### hw/rtl/periodic_timer_queue_unit.sv
// ============================================================================
// periodic_timer_queue_unit - table of periodic timers
// Set, kill, poll and wait-time queries over a table of MAX_TIMERS slots,
// one slot compared per cycle.
//
//   channel  | role   | beat contents
//   ---------+--------+--------------------------------------------------
//   req_ch   | sink   | action, timer_id, interval_ms, now_ms
//   rsp_ch   | source | fired, fired_id, wait_ms, is_empty, status
//
// A request is handled in steps: accept, a scan of every slot through the
// single slot read port, a compare of the last slot, then the commit. The
// next request is taken while a result beat still waits in the output
// register; its commit holds until that beat is taken. Synchronous reset
// clears all slots at once.
// ============================================================================
module periodic_timer_queue_unit #(
   parameter int MAX_TIMERS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ptq_req_if.sink   req_ch,
   ptq_rsp_if.source rsp_ch
);

   localparam int IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

   ptq_pkg::ctrl_cmd_type  cmd;
   ptq_pkg::dp_status_type status;
   logic [IdxW-1:0]        scan_addr;

   // Sequencer
   ptq_controller #(
      .MAX_TIMERS(MAX_TIMERS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .cmd      (cmd),
      .scan_addr(scan_addr)
   );

   // Slot table and result register
   ptq_datapath #(
      .MAX_TIMERS(MAX_TIMERS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .cmd      (cmd),
      .scan_addr(scan_addr),
      .status   (status)
   );

endmodule

### hw/rtl/ptq_controller.sv
// ============================================================================
// ptq_controller - sequencer of the timer queue
// Takes one request, sweeps the slot address across the table, waits for
// the last read to be compared, then commits once the result slot is free.
// ============================================================================
module ptq_controller #(
   parameter int  MAX_TIMERS = 16,
   localparam int IdxW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptq_pkg::dp_status_type status,
   output ptq_pkg::ctrl_cmd_type  cmd,
   output logic [IdxW-1:0]        scan_addr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   localparam logic [IdxW-1:0] LastAddr = IdxW'(MAX_TIMERS - 1);

   state_type       state_ff;
   logic [IdxW-1:0] addr_ff;

   // Decode commands from the current state
   always_comb begin
      cmd.req_ready = (state_ff == ST_IDLE);
      cmd.load_item = (state_ff == ST_IDLE) && status.req_valid;
      cmd.issue     = (state_ff == ST_SCAN);
      cmd.commit    = (state_ff == ST_COMMIT) && !status.out_busy;
   end

   assign scan_addr = addr_ff;

   // Advance state and the scan address
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               addr_ff <= '0;
               if (status.req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (addr_ff == LastAddr) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/ptq_datapath.sv
// ============================================================================
// ptq_datapath - timer table, scan trackers and result register
// Holds slot storage, compares one slot per cycle against the request,
// and applies the set, kill or re-arm when the controller commits.
// ============================================================================
module ptq_datapath #(
   parameter int  MAX_TIMERS = 16,
   localparam int IdxW       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   ptq_req_if.sink                req_ch,
   ptq_rsp_if.source              rsp_ch,
   input  ptq_pkg::ctrl_cmd_type  cmd,
   input  logic [IdxW-1:0]        scan_addr,
   output ptq_pkg::dp_status_type status
);

   localparam int IdW   = ptq_pkg::ID_W;
   localparam int IntvW = ptq_pkg::INTV_W;
   localparam int NowW  = ptq_pkg::NOW_W;
   localparam int DlW   = ptq_pkg::DL_W;
   localparam int WaitW = ptq_pkg::WAIT_W;

   // Slot storage
   logic [MAX_TIMERS-1:0] valid_ff;
   logic [MAX_TIMERS-1:0] valid_in;
   logic [IdW-1:0]        mem_id   [MAX_TIMERS];
   logic [IntvW-1:0]      mem_intv [MAX_TIMERS];
   logic [DlW-1:0]        mem_dl   [MAX_TIMERS];

   // Captured request
   ptq_pkg::action_type act_ff;
   logic [IdW-1:0]      id_ff;
   logic [IntvW-1:0]    intv_ff;
   logic [NowW-1:0]     now_ff;

   // Read stage
   logic                rd_vld_ff;
   logic [IdxW-1:0]     rd_idx_ff;
   logic [IdW-1:0]      rd_id_ff;
   logic [IntvW-1:0]    rd_intv_ff;
   logic [DlW-1:0]      rd_dl_ff;

   // Scan trackers
   logic                match_hit_ff;
   logic [IdxW-1:0]     match_idx_ff;
   logic                free_hit_ff;
   logic [IdxW-1:0]     free_idx_ff;
   logic                best_hit_ff;
   logic [IdxW-1:0]     best_idx_ff;
   logic [DlW-1:0]      best_dl_ff;
   logic [IdW-1:0]      best_id_ff;
   logic [IntvW-1:0]    best_intv_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                fired_ff;
   logic [IdW-1:0]      fired_id_ff;
   logic [WaitW-1:0]    wait_ff;
   logic                empty_ff;
   logic                status_ff;

   // Commit-side signals
   logic                slot_on;
   logic                earlier;
   logic                tgt_hit;
   logic [IdxW-1:0]     tgt_idx;
   logic [DlW-1:0]      now_ext;
   logic [DlW-1:0]      set_dl;
   logic [DlW:0]        rearm_sum;
   logic [DlW-1:0]      rearm_dl;
   logic                poll_due;
   logic [DlW-1:0]      wait_diff;
   logic [WaitW-1:0]    wait_val;
   logic                wr_set;
   logic                wr_dl;
   logic [IdxW-1:0]     wr_idx;
   logic [DlW-1:0]      wr_dl_val;
   logic                fired_in;
   logic [WaitW-1:0]    wait_in;
   logic                status_in;

   // Handshake toward controller and channels
   assign req_ch.ready     = cmd.req_ready;
   assign status.req_valid = req_ch.valid;
   assign status.out_busy  = rsp_valid_ff && !rsp_ch.ready;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.fired    = fired_ff;
   assign rsp_ch.fired_id = fired_id_ff;
   assign rsp_ch.wait_ms  = wait_ff;
   assign rsp_ch.is_empty = empty_ff;
   assign rsp_ch.status   = status_ff;

   // Compare the slot just read against the trackers
   assign slot_on = rd_vld_ff && valid_ff[rd_idx_ff];
   assign earlier = !best_hit_ff || (rd_dl_ff < best_dl_ff) ||
                    ((rd_dl_ff == best_dl_ff) && (rd_id_ff < best_id_ff));

   // Choose the slot for a set: lowest free slot once the match is removed
   assign tgt_hit = match_hit_ff || free_hit_ff;
   assign tgt_idx = (free_hit_ff && (!match_hit_ff || (free_idx_ff < match_idx_ff))) ?
                    free_idx_ff : match_idx_ff;

   // Deadline arithmetic
   assign now_ext   = DlW'(now_ff);
   assign set_dl    = now_ext + DlW'(intv_ff);
   assign rearm_sum = {1'b0, best_dl_ff} + (DlW + 1)'(best_intv_ff);
   assign rearm_dl  = rearm_sum[DlW] ? {DlW{1'b1}} : rearm_sum[DlW-1:0];
   assign poll_due  = best_hit_ff && (now_ext >= best_dl_ff);
   assign wait_diff = best_dl_ff - now_ext;

   // Wait time: the empty default, zero once the deadline is past, else the distance saturated
   always_comb begin
      if (!best_hit_ff) begin
         wait_val = ptq_pkg::WAIT_WHEN_EMPTY;
      end else if (now_ext > best_dl_ff) begin
         wait_val = '0;
      end else if (|wait_diff[DlW-1:WaitW]) begin
         wait_val = {WaitW{1'b1}};
      end else begin
         wait_val = wait_diff[WaitW-1:0];
      end
   end

   // Table update and result values for the committed action
   always_comb begin
      valid_in  = valid_ff;
      wr_set    = 1'b0;
      wr_dl     = 1'b0;
      wr_idx    = best_idx_ff;
      wr_dl_val = rearm_dl;
      fired_in  = 1'b0;
      wait_in   = '0;
      status_in = 1'b0;
      if (cmd.commit) begin
         unique case (act_ff)
            ptq_pkg::ACT_SET: begin
               if (tgt_hit) begin
                  if (match_hit_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                  end
                  valid_in[tgt_idx] = 1'b1;
                  wr_set    = 1'b1;
                  wr_dl     = 1'b1;
                  wr_idx    = tgt_idx;
                  wr_dl_val = set_dl;
               end else begin
                  status_in = 1'b1;
               end
            end
            ptq_pkg::ACT_KILL: begin
               if (match_hit_ff) begin
                  valid_in[match_idx_ff] = 1'b0;
               end
            end
            ptq_pkg::ACT_POLL: begin
               if (poll_due) begin
                  wr_dl    = 1'b1;
                  fired_in = 1'b1;
               end
            end
            ptq_pkg::ACT_WAIT: begin
               wait_in = wait_val;
            end
            default: begin
               wait_in = '0;
            end
         endcase
      end
   end

   // Slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_set) begin
         mem_id[wr_idx]   <= id_ff;
         mem_intv[wr_idx] <= intv_ff;
      end
      if (wr_dl) begin
         mem_dl[wr_idx] <= wr_dl_val;
      end
      if (cmd.issue) begin
         rd_id_ff   <= mem_id[scan_addr];
         rd_intv_ff <= mem_intv[scan_addr];
         rd_dl_ff   <= mem_dl[scan_addr];
      end
      rd_idx_ff <= scan_addr;
   end

   // Capture the request beat and track the scan
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff       <= ptq_pkg::action_type'(req_ch.action);
         id_ff        <= req_ch.timer_id;
         intv_ff      <= req_ch.interval_ms;
         now_ff       <= req_ch.now_ms;
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         best_hit_ff  <= 1'b0;
      end else if (rd_vld_ff) begin
         if (slot_on && (rd_id_ff == id_ff) && !match_hit_ff) begin
            match_hit_ff <= 1'b1;
            match_idx_ff <= rd_idx_ff;
         end
         if (!slot_on && !free_hit_ff) begin
            free_hit_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (slot_on && earlier) begin
            best_hit_ff  <= 1'b1;
            best_idx_ff  <= rd_idx_ff;
            best_dl_ff   <= rd_dl_ff;
            best_id_ff   <= rd_id_ff;
            best_intv_ff <= rd_intv_ff;
         end
      end
   end

   // Load the result payload on commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         fired_ff    <= fired_in;
         fired_id_ff <= fired_in ? best_id_ff : '0;
         wait_ff     <= wait_in;
         empty_ff    <= ~|valid_in;
         status_ff   <= status_in;
      end
   end

   // Control registers: slot valid bits, read valid, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_vld_ff <= cmd.issue;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
